### sv/wih_pkg.sv
// ----------------------------------------------------------------------------
// wih_pkg
// Shared constants, request codes and control types of the windowed
// inversion histogram.
// ----------------------------------------------------------------------------
package wih_pkg;

    localparam int MAX_SIZE_DEF = 8;
    localparam int BINS_DEF     = 64;
    localparam int WIN_W        = 3;
    localparam int CNT_W        = 16;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_RUN,
        T_HRD,
        T_RDW,
        T_RESP
    } top_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SCORE,
        E_WAIT,
        E_NEXT,
        E_SW_A,
        E_SW_B,
        E_SW_C,
        E_DONE
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic win_we;
    } eng_ctrl_t;

    typedef struct packed {
        logic score_valid;
        logic done;
    } eng_stat_t;

endpackage

### sv/wih_ram.sv
// ----------------------------------------------------------------------------
// wih_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wih_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/wih_perm_engine.sv
// ----------------------------------------------------------------------------
// wih_perm_engine
// Walks all permutations of 1..n with an iterative swap sequence and scores
// each one, one position per cycle, against the look-ahead window table.
// ----------------------------------------------------------------------------
module wih_perm_engine #(
    parameter int MAX_SIZE = wih_pkg::MAX_SIZE_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  wih_pkg::eng_ctrl_t                     ctrl,
    input  logic [$clog2(MAX_SIZE+1)-1:0]          size,
    input  logic [$clog2(MAX_SIZE)-1:0]            win_addr,
    input  logic [wih_pkg::WIN_W-1:0]              win_data,
    output wih_pkg::eng_stat_t                     stat,
    output logic [$clog2(7*MAX_SIZE+1)-1:0]        drops
);

    import wih_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE+1);
    localparam int SW = $clog2(7*MAX_SIZE+1);
    localparam int PW = NW + 3;

    eng_state_t state_reg, state_next;

    logic [NW-1:0]    perm_reg [MAX_SIZE];
    logic [IW-1:0]    cnt_reg  [MAX_SIZE];
    logic [WIN_W-1:0] win_reg  [MAX_SIZE];
    logic [NW-1:0]    idx_reg;
    logic [IW-1:0]    x_reg;
    logic [SW-1:0]    acc_reg;
    logic [IW-1:0]    sa_reg, sb_reg;
    logic [NW-1:0]    tmp_reg;

    logic [IW-1:0]    rd_idx;
    logic [NW-1:0]    perm_x;
    logic             x_last;
    logic [WIN_W-1:0] w_eff;
    logic [PW-1:0]    x_ext, reach, size_ext;
    logic [MAX_SIZE-1:0] hit;
    logic [PW-1:0]    beyond;
    logic [SW-1:0]    acc_next;
    logic             idx_done;
    logic [IW-1:0]    idx_cut;
    logic [IW-1:0]    cnt_i;
    logic             heap_swap;

    always_comb begin
        unique case (state_reg)
            E_SW_A:  rd_idx = sa_reg;
            E_SW_B:  rd_idx = sb_reg;
            default: rd_idx = x_reg;
        endcase
    end

    assign perm_x   = perm_reg[rd_idx];
    assign x_ext    = PW'(x_reg);
    assign size_ext = PW'(size);
    assign x_last   = (x_ext + PW'(1)) == size_ext;
    assign w_eff    = x_last ? '0 : win_reg[x_reg];
    assign reach    = x_ext + PW'(w_eff);

    // lanes compare the current place against each later place in window
    always_comb begin
        for (int j = 0; j < MAX_SIZE; j++) begin
            hit[j] = (PW'(j) > x_ext) && (PW'(j) <= reach) && (PW'(j) < size_ext)
                     && (perm_x > perm_reg[j]);
        end
    end

    // places past the end read as zero and always count
    assign beyond   = (reach >= size_ext) ? (reach - size_ext + PW'(1)) : '0;
    assign acc_next = acc_reg + SW'($countones(hit)) + SW'(beyond);

    assign idx_done  = idx_reg >= size;
    assign idx_cut   = idx_reg[IW-1:0];
    assign cnt_i     = cnt_reg[idx_cut];
    assign heap_swap = NW'(cnt_i) < idx_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:  if (ctrl.start) state_next = E_SCORE;
            E_SCORE: if (x_last) state_next = E_WAIT;
            E_WAIT:  if (ctrl.step) state_next = E_NEXT;
            E_NEXT: begin
                if (idx_done) begin
                    state_next = E_DONE;
                end else if (heap_swap) begin
                    state_next = E_SW_A;
                end
            end
            E_SW_A:  state_next = E_SW_B;
            E_SW_B:  state_next = E_SW_C;
            E_SW_C:  state_next = E_SCORE;
            E_DONE:  state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_comb begin
        stat.score_valid = (state_reg == E_WAIT);
        stat.done        = (state_reg == E_DONE);
    end

    assign drops = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            for (int k = 0; k < MAX_SIZE; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (ctrl.win_we) begin
                win_reg[win_addr] <= win_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            E_IDLE: begin
                for (int k = 0; k < MAX_SIZE; k++) begin
                    perm_reg[k] <= NW'(k + 1);
                    cnt_reg[k]  <= '0;
                end
                idx_reg <= NW'(1);
                x_reg   <= '0;
                acc_reg <= '0;
            end
            E_SCORE: begin
                acc_reg <= acc_next;
                if (!x_last) begin
                    x_reg <= x_reg + IW'(1);
                end
            end
            E_NEXT: begin
                if (!idx_done) begin
                    if (heap_swap) begin
                        sa_reg           <= idx_cut[0] ? cnt_i : '0;
                        sb_reg           <= idx_cut;
                        cnt_reg[idx_cut] <= cnt_i + IW'(1);
                        idx_reg          <= NW'(1);
                    end else begin
                        cnt_reg[idx_cut] <= '0;
                        idx_reg          <= idx_reg + NW'(1);
                    end
                end
            end
            E_SW_A: tmp_reg <= perm_x;
            E_SW_B: perm_reg[sa_reg] <= perm_x;
            E_SW_C: begin
                perm_reg[sb_reg] <= tmp_reg;
                x_reg            <= '0;
                acc_reg          <= '0;
            end
            default: ;
        endcase
    end

endmodule

### sv/windowed_inversion_histogram.sv
// ----------------------------------------------------------------------------
// windowed_inversion_histogram
// Scores every permutation of 1..n by windowed drop count into a histogram.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A window write passes through the response state
// and the output register; a bin read first passes a RAM read state as well.
// A run first sweeps the histogram RAM to zero, then for each permutation
// scores it one position per cycle, does a read-modify-write of its bin, runs
// the sequencing steps and the swap states E_SW_A, E_SW_B and E_SW_C. After
// reset the same clearing sweep runs before the first beat is taken. The
// user must write perm_size only while the block is idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module windowed_inversion_histogram #(
    parameter int MAX_SIZE = wih_pkg::MAX_SIZE_DEF,
    parameter int BINS     = wih_pkg::BINS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // perm_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // position[2:0], window[5:3], bin[11:6]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value[15:0]
    output logic        m_axis_tuser    // status
);

    import wih_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE+1);
    localparam int SW = $clog2(7*MAX_SIZE+1);
    localparam int BW = $clog2(BINS);

    top_state_t state_reg, state_next;

    logic [3:0]       size_reg;
    logic [BW-1:0]    clr_reg;
    logic             run_pend_reg;
    logic [BW-1:0]    hbin_reg;
    logic [CNT_W-1:0] scored_reg;
    logic [CNT_W-1:0] res_value_reg;
    logic             res_status_reg;
    logic             m_valid_reg;
    logic [CNT_W-1:0] m_data_reg;
    logic             m_status_reg;

    logic       accept;
    req_t       req;
    logic [2:0] in_pos;
    logic [2:0] in_win;
    logic [5:0] in_bin;
    logic       pos_ok, bin_ok;
    logic [NW-1:0] n_eff;
    logic       out_free;

    eng_ctrl_t  eng_ctrl;
    eng_stat_t  eng_stat;
    logic [SW-1:0] drops;
    logic [BW-1:0] drop_bin;

    logic             ram_we;
    logic [BW-1:0]    ram_waddr, ram_raddr;
    logic [CNT_W-1:0] ram_wdata, ram_rdata;

    assign req    = req_t'(s_axis_tuser);
    assign in_pos = s_axis_tdata[2:0];
    assign in_win = s_axis_tdata[5:3];
    assign in_bin = s_axis_tdata[11:6];
    assign pos_ok = 32'(in_pos) < MAX_SIZE;
    assign bin_ok = 32'(in_bin) < BINS;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // zero means one, anything past the top means the top
    assign n_eff = (size_reg == 4'd0) ? NW'(1) :
                   (32'(size_reg) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_reg);

    assign drop_bin = (32'(drops) >= BINS - 1) ? BW'(BINS - 1) : BW'(drops);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_CLEAR: if (32'(clr_reg) == BINS - 1) state_next = run_pend_reg ? T_RUN : T_IDLE;
            T_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_RUN:  state_next = T_CLEAR;
                        REQ_READ: state_next = bin_ok ? T_RDW : T_RESP;
                        default:  state_next = T_RESP;
                    endcase
                end
            end
            T_RUN: begin
                if (eng_stat.score_valid) begin
                    state_next = T_HRD;
                end else if (eng_stat.done) begin
                    state_next = T_RESP;
                end
            end
            T_HRD:   state_next = T_RUN;
            T_RDW:   state_next = T_RESP;
            T_RESP:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = (state_reg == T_IDLE);
        eng_ctrl.start  = (state_reg == T_CLEAR) && run_pend_reg && (32'(clr_reg) == BINS - 1);
        eng_ctrl.step   = (state_reg == T_HRD);
        eng_ctrl.win_we = accept && (req == REQ_WRITE) && pos_ok;
        ram_we          = (state_reg == T_CLEAR) || (state_reg == T_HRD);
        ram_waddr       = (state_reg == T_CLEAR) ? clr_reg : hbin_reg;
        ram_wdata       = '0;
        if (state_reg == T_HRD) begin
            ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
        end
        ram_raddr = (state_reg == T_RUN) ? drop_bin : BW'(in_bin);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            size_reg     <= 4'd1;
            clr_reg      <= '0;
            run_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (state_reg == T_CLEAR) begin
                if (32'(clr_reg) == BINS - 1) begin
                    clr_reg      <= '0;
                    run_pend_reg <= 1'b0;
                end else begin
                    clr_reg <= clr_reg + BW'(1);
                end
            end
            if (accept && req == REQ_RUN) begin
                run_pend_reg <= 1'b1;
            end
            if (state_reg == T_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_value_reg  <= '0;
            scored_reg     <= '0;
            unique case (req)
                REQ_WRITE: res_status_reg <= !pos_ok;
                REQ_RUN:   res_status_reg <= 1'b0;
                REQ_READ:  res_status_reg <= !bin_ok;
                default:   res_status_reg <= 1'b1;
            endcase
        end
        if (state_reg == T_RUN && eng_stat.score_valid) begin
            hbin_reg <= drop_bin;
        end
        if (state_reg == T_HRD && scored_reg != '1) begin
            scored_reg <= scored_reg + CNT_W'(1);
        end
        if (state_reg == T_RUN && eng_stat.done) begin
            res_value_reg <= scored_reg;
        end
        if (state_reg == T_RDW) begin
            res_value_reg <= ram_rdata;
        end
        if (state_reg == T_RESP && out_free) begin
            m_data_reg   <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

    wih_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BINS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wih_perm_engine #(
        .MAX_SIZE (MAX_SIZE)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (eng_ctrl),
        .size     (n_eff),
        .win_addr (IW'(in_pos)),
        .win_data (in_win),
        .stat     (eng_stat),
        .drops    (drops)
    );

`ifndef SYNTHESIS
    a_score_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.score_valid |-> (state_reg == T_RUN || state_reg == T_HRD))
        else $error("score offered outside a run");

    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.done |-> state_reg == T_RUN)
        else $error("engine finished outside a run");

    a_bin_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_HRD) |-> (ram_we && ram_waddr == hbin_reg && eng_ctrl.step))
        else $error("bin update lost");

    a_resp_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_RESP && out_free) |=> m_valid_reg)
        else $error("result not presented");
`endif

endmodule

### sim/windowed_inversion_histogram_test.sv
// ----------------------------------------------------------------------------
// windowed_inversion_histogram_test
// Self-checking bench: directed table, then random request sequences; each
// result vs typed row value or in-bench permutation histogram predictor.
// ----------------------------------------------------------------------------
module windowed_inversion_histogram_test;
    import wih_pkg::*;

    localparam int MAXN      = MAX_SIZE_DEF;
    localparam int NBINS     = BINS_DEF;
    localparam int CNT_SAT   = 65535;
    localparam int LIMIT     = 4000000;
    localparam int HOLD_LEN  = 600;
    localparam int RAND_ITEMS = 80;

    typedef struct {
        logic        is_cfg;
        logic [3:0]  size;
        req_t        req;
        logic [2:0]  pos;
        logic [2:0]  win;
        logic [5:0]  bin;
        logic        typed;
        logic [15:0] value;
        logic        status;
    } row_t;

    typedef struct {
        logic [15:0] value;
        logic        status;
    } resp_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    windowed_inversion_histogram dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [2:0]  win_tbl [MAXN];
    int unsigned hist    [NBINS];
    logic [3:0]  size_reg;

    resp_t       pending_q[$];
    int          errors;
    int          cycles;
    int          burst_left;
    bit          hold_req;
    int          n_writes, n_runs, n_reads, n_other, n_checked;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("windowed_inversion_histogram_test: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    endtask

    // enumerate all permutations of 1..n, bin each drop count
    function automatic int unsigned score_all(int n);
        int p [MAXN];
        int i, j, k, x, y, w, cnt, right, t;
        int unsigned perms;
        bit more;
        perms = 0;
        for (i = 0; i < NBINS; i++) hist[i] = 0;
        for (i = 0; i < n; i++) p[i] = i + 1;
        more = 1;
        while (more) begin
            cnt = 0;
            for (x = 0; x < n; x++) begin
                w = (x == n - 1) ? 0 : int'(win_tbl[x]);
                for (y = 1; y <= w; y++) begin
                    right = (x + y < n) ? p[x + y] : 0;
                    if (p[x] > right) cnt++;
                end
            end
            if (cnt > NBINS - 1) cnt = NBINS - 1;
            if (hist[cnt] < CNT_SAT) hist[cnt]++;
            if (perms < CNT_SAT) perms++;
            // lexicographic successor
            i = n - 2;
            while (i >= 0 && p[i] > p[i + 1]) i--;
            if (i < 0) begin
                more = 0;
            end else begin
                j = n - 1;
                while (p[j] < p[i]) j--;
                t = p[i]; p[i] = p[j]; p[j] = t;
                j = i + 1;
                k = n - 1;
                while (j < k) begin
                    t = p[j]; p[j] = p[k]; p[k] = t;
                    j++; k--;
                end
            end
        end
        return perms;
    endfunction

    function automatic resp_t predict(req_t req, logic [2:0] pos, logic [2:0] win,
                                      logic [5:0] bin);
        resp_t r;
        int n;
        r.value  = '0;
        r.status = 1'b0;
        case (req)
            REQ_WRITE: begin
                if (pos < MAXN) win_tbl[pos] = win;
                else r.status = 1'b1;
            end
            REQ_RUN: begin
                n = (size_reg < 1) ? 1 : (size_reg > MAXN) ? MAXN : int'(size_reg);
                r.value = 16'(score_all(n));
            end
            REQ_READ: begin
                if (bin < NBINS) r.value = 16'(hist[bin]);
                else r.status = 1'b1;
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    task automatic send_beat(row_t rw);
        resp_t r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 10);
        end else begin
            @(negedge aclk);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = rw.req;
        s_axis_tdata  = {4'd0, rw.bin, rw.win, rw.pos};
        do @(posedge aclk); while (!s_axis_tready);
        r = predict(rw.req, rw.pos, rw.win, rw.bin);
        if (rw.typed) begin
            r.value  = rw.value;
            r.status = rw.status;
        end
        pending_q.push_back(r);
        case (rw.req)
            REQ_WRITE: n_writes++;
            REQ_RUN:   n_runs++;
            REQ_READ:  n_reads++;
            default:   n_other++;
        endcase
    endtask

    task automatic write_size(logic [3:0] sz);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = sz;
        @(negedge aclk);
        cfg_we   = 1'b0;
        size_reg = sz;
    endtask

    function automatic row_t mk(req_t req, int pos, int win, int bin,
                                bit typed = 0, int value = 0, bit status = 0);
        row_t rw;
        rw.is_cfg = 0;
        rw.size   = '0;
        rw.req    = req;
        rw.pos    = 3'(pos);
        rw.win    = 3'(win);
        rw.bin    = 6'(bin);
        rw.typed  = typed;
        rw.value  = 16'(value);
        rw.status = status;
        return rw;
    endfunction

    function automatic row_t mk_cfg(int sz);
        row_t rw;
        rw = mk(REQ_NONE, 0, 0, 0);
        rw.is_cfg = 1;
        rw.size   = 4'(sz);
        return rw;
    endfunction

    // response checker
    always @(posedge aclk) begin
        resp_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat, value", m_axis_tdata, -1);
            end else begin
                e = pending_q.pop_front();
                n_checked++;
                if (m_axis_tdata !== e.value) report_mismatch("value", m_axis_tdata, e.value);
                if (m_axis_tuser !== e.status)
                    report_mismatch("status", m_axis_tuser, e.status);
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                for (hold = 0; hold < HOLD_LEN; hold++) @(negedge aclk);
                hold_req = 1'b0;
            end else if (cycles[7]) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial begin
        row_t table_rows [$];
        int i, phase, cnt, k;
        int unsigned pick;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_WRITE;
        errors = 0; cycles = 0; burst_left = 0; hold_req = 0;
        n_writes = 0; n_runs = 0; n_reads = 0; n_other = 0; n_checked = 0;
        for (i = 0; i < MAXN; i++) win_tbl[i] = '0;
        for (i = 0; i < NBINS; i++) hist[i] = 0;
        size_reg = 4'd1;

        // directed part
        table_rows.push_back(mk_cfg(0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 63, 1, 0, 0));
        table_rows.push_back(mk(REQ_RUN, 0, 0, 0, 1, 1, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 0, 1, 1, 0));
        table_rows.push_back(mk(REQ_NONE, 7, 7, 63, 1, 0, 1));
        table_rows.push_back(mk(REQ_WRITE, 0, 7, 0, 1, 0, 0));
        table_rows.push_back(mk(REQ_WRITE, 7, 7, 63, 1, 0, 0));
        table_rows.push_back(mk_cfg(2));
        table_rows.push_back(mk(REQ_RUN, 0, 0, 0, 1, 2, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 6));
        table_rows.push_back(mk(REQ_READ, 0, 0, 7));
        table_rows.push_back(mk(REQ_WRITE, 1, 2, 0));
        table_rows.push_back(mk(REQ_WRITE, 3, 5, 0));
        table_rows.push_back(mk(REQ_WRITE, 6, 1, 0));
        // out-of-range size clamps to the maximum
        table_rows.push_back(mk_cfg(15));
        table_rows.push_back(mk(REQ_RUN, 0, 0, 0, 1, 40320, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 20));
        table_rows.push_back(mk(REQ_READ, 0, 0, 63));
        table_rows.push_back(mk_cfg(8));
        table_rows.push_back(mk(REQ_READ, 0, 0, 10));
        table_rows.push_back(mk_cfg(3));
        table_rows.push_back(mk(REQ_RUN, 0, 0, 0, 1, 6, 0));
        table_rows.push_back(mk(REQ_READ, 0, 0, 9));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < table_rows.size(); i++) begin
            if (table_rows[i].is_cfg) write_size(table_rows[i].size);
            else send_beat(table_rows[i]);
        end

        // random part: per phase a new size, then write/run/read/unused sequences
        cnt = 0;
        phase = 0;
        while (cnt < RAND_ITEMS) begin
            write_size(phase == 3 ? 4'd7 : 4'($urandom_range(0, 6)));
            if (phase == 1) hold_req = 1'b1;
            k = 0;
            while (k < 17) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_beat(mk(REQ_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                                 $urandom_range(0, 63)));
                    k++;
                end else begin
                    repeat ($urandom_range(0, 3)) begin
                        send_beat(mk(REQ_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                                     $urandom_range(0, 63)));
                        k++;
                    end
                    if ($urandom_range(0, 3) != 0) begin
                        send_beat(mk(REQ_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                                     $urandom_range(0, 63)));
                        k++;
                    end
                    repeat ($urandom_range(2, 6)) begin
                        send_beat(mk(REQ_READ, $urandom_range(0, 7), $urandom_range(0, 7),
                                     ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15)
                                                                 : $urandom_range(0, 63)));
                        k++;
                    end
                end
            end
            cnt += k;
            phase++;
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d writes, %0d runs, %0d bin reads, %0d unused requests",
                 n_writes, n_runs, n_reads, n_other);
        $display("%0d result beats checked over %0d phases, %0d mismatches",
                 n_checked, phase, errors);
        if (errors == 0) begin
            $display("windowed_inversion_histogram_test: done, clean");
        end else begin
            $display("windowed_inversion_histogram_test: done, errors");
        end
        $finish;
    end

endmodule
